>>> hw/rtl/mm_pkg.sv
// Shared types and constants for the matrix multiply block.
package mm_pkg;

    // Result word fields
    localparam int ACC_W = 35;
    localparam int IDX_W = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd2;

    // Output stream word: value, row, col, padded to whole bytes
    localparam int OUT_DATA_W = ((ACC_W + 2 * IDX_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - ACC_W - 2 * IDX_W;

    // Tag travelling with each multiply-accumulate step
    typedef struct packed {
        logic             valid;
        logic             first;   // first term of a sum
        logic             lastk;   // final term of a sum
        logic             last;    // sum is the final result element
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } mac_tag_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     wr_en;  // store the incoming element
        logic     wr_b;   // element belongs to B
        mac_tag_t tag;    // read both stores and feed the MAC
    } dp_cmd_t;

    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } out_entry_t;

endpackage

>>> hw/rtl/mm_ctrl.sv
// Controller: configuration registers, load counter and the row/column/inner loop sequencer.
module mm_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          out_pop,
    output mm_pkg::dp_cmd_t               cmd,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] a_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] b_addr
);

    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int JW  = $clog2(MAX_DIM);
    localparam int AW  = $clog2(MAX_DIM * MAX_DIM);
    localparam int CW  = $clog2(2 * MAX_DIM * MAX_DIM + 1);
    localparam int CMW = (DW > mm_pkg::CFG_DATA_W) ? DW : mm_pkg::CFG_DATA_W;

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_MAC  = 1'b1;

    localparam logic [1:0] CREDITS = 2'd2;

    logic                          state_reg, state_next;
    logic [mm_pkg::CFG_DATA_W-1:0] rows_reg, rows_next;
    logic [mm_pkg::CFG_DATA_W-1:0] inner_reg, inner_next;
    logic [mm_pkg::CFG_DATA_W-1:0] cols_reg, cols_next;
    logic [CW-1:0]                 load_count_reg, load_count_next;
    logic [JW-1:0]                 j_reg, j_next;
    logic [JW-1:0]                 i_reg, i_next;
    logic [JW-1:0]                 k_reg, k_next;
    logic [AW-1:0]                 a_base_reg, a_base_next;
    logic [AW-1:0]                 a_addr_reg, a_addr_next;
    logic [AW-1:0]                 b_addr_reg, b_addr_next;
    logic [1:0]                    credit_reg, credit_next;

    logic [DW-1:0] dim_r, dim_n, dim_c;
    logic [CW-1:0] a_len, b_len, total_len;
    logic          in_b;
    logic          issue, take, k_end, i_end, j_end;

    // Out-of-range dimensions: zero acts as one, above MAX_DIM saturates
    always_comb
    begin
        dim_r = (rows_reg == '0) ? DW'(1) :
                ((CMW'(rows_reg) > CMW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(rows_reg));
        dim_n = (inner_reg == '0) ? DW'(1) :
                ((CMW'(inner_reg) > CMW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(inner_reg));
        dim_c = (cols_reg == '0) ? DW'(1) :
                ((CMW'(cols_reg) > CMW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cols_reg));
    end

    assign a_len     = CW'(dim_r) * CW'(dim_n);
    assign b_len     = CW'(dim_n) * CW'(dim_c);
    assign total_len = a_len + b_len;
    assign in_b      = (load_count_reg >= a_len);
    assign wr_addr   = in_b ? AW'(load_count_reg - a_len) : AW'(load_count_reg);

    assign k_end = (DW'(k_reg) == dim_n - DW'(1));
    assign i_end = (DW'(i_reg) == dim_c - DW'(1));
    assign j_end = (DW'(j_reg) == dim_r - DW'(1));

    // A new sum starts only when the output queue has room reserved for it
    assign issue = (state_reg == ST_MAC) && ((k_reg != '0) || (credit_reg != 2'd0));
    assign take  = issue && (k_reg == '0);

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_LOAD);
    assign a_addr    = a_addr_reg;
    assign b_addr    = b_addr_reg;

    always_comb
    begin
        state_next      = state_reg;
        rows_next       = rows_reg;
        inner_next      = inner_reg;
        cols_next       = cols_reg;
        load_count_next = load_count_reg;
        j_next          = j_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        a_base_next     = a_base_reg;
        a_addr_next     = a_addr_reg;
        b_addr_next     = b_addr_reg;
        cmd             = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_b  = in_b;
                    if (load_count_reg + CW'(1) == total_len)
                    begin
                        load_count_next = '0;
                        state_next      = ST_MAC;
                        j_next          = '0;
                        i_next          = '0;
                        k_next          = '0;
                        a_base_next     = '0;
                        a_addr_next     = '0;
                        b_addr_next     = '0;
                    end
                    else
                    begin
                        load_count_next = load_count_reg + CW'(1);
                    end
                end
            end
            ST_MAC:
            begin
                if (issue)
                begin
                    cmd.tag.valid = 1'b1;
                    cmd.tag.first = (k_reg == '0);
                    cmd.tag.lastk = k_end;
                    cmd.tag.last  = j_end && i_end;
                    cmd.tag.row   = mm_pkg::IDX_W'(j_reg);
                    cmd.tag.col   = mm_pkg::IDX_W'(i_reg);
                    if (k_end)
                    begin
                        k_next = '0;
                        if (i_end)
                        begin
                            i_next      = '0;
                            b_addr_next = '0;
                            if (j_end)
                            begin
                                state_next = ST_LOAD;
                            end
                            else
                            begin
                                j_next      = j_reg + JW'(1);
                                a_base_next = a_base_reg + AW'(dim_n);
                                a_addr_next = a_base_reg + AW'(dim_n);
                            end
                        end
                        else
                        begin
                            i_next      = i_reg + JW'(1);
                            a_addr_next = a_base_reg;
                            b_addr_next = AW'(i_reg) + AW'(1);
                        end
                    end
                    else
                    begin
                        k_next      = k_reg + JW'(1);
                        a_addr_next = a_addr_reg + AW'(1);
                        b_addr_next = b_addr_reg + AW'(dim_c);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // A write to a mapped register abandons any partial load
        if (cfg_valid)
        begin
            unique case (cfg_index)
                mm_pkg::REG_ROWS:
                begin
                    rows_next       = cfg_data;
                    load_count_next = '0;
                end
                mm_pkg::REG_INNER:
                begin
                    inner_next      = cfg_data;
                    load_count_next = '0;
                end
                mm_pkg::REG_COLS:
                begin
                    cols_next       = cfg_data;
                    load_count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case ({take, out_pop})
            2'b10:   credit_next = credit_reg - 2'd1;
            2'b01:   credit_next = credit_reg + 2'd1;
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            rows_reg       <= 4'd8;
            inner_reg      <= 4'd8;
            cols_reg       <= 4'd8;
            load_count_reg <= '0;
            j_reg          <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            a_base_reg     <= '0;
            a_addr_reg     <= '0;
            b_addr_reg     <= '0;
            credit_reg     <= CREDITS;
        end
        else
        begin
            state_reg      <= state_next;
            rows_reg       <= rows_next;
            inner_reg      <= inner_next;
            cols_reg       <= cols_next;
            load_count_reg <= load_count_next;
            j_reg          <= j_next;
            i_reg          <= i_next;
            k_reg          <= k_next;
            a_base_reg     <= a_base_next;
            a_addr_reg     <= a_addr_next;
            b_addr_reg     <= b_addr_next;
            credit_reg     <= credit_next;
        end
    end

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CREDITS)
        else $error("output credit above queue depth");

    a_sum_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tag.valid && cmd.tag.first) |-> (credit_reg != 2'd0))
        else $error("sum started with no free output slot");

    a_mac_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_MAC) |-> $past(cmd.wr_en))
        else $error("compute entered without a completing element");

endmodule

>>> hw/rtl/mm_datapath.sv
// Datapath: A and B element stores, shared multiply-accumulate and two-entry result queue.
module mm_datapath #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mm_pkg::dp_cmd_t                      cmd,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   wr_addr,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   a_addr,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   b_addr,
    input  logic signed [ELEM_WIDTH-1:0]         element,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output mm_pkg::out_entry_t                   out_entry,
    output logic                                 out_pop
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int PW    = 2 * ELEM_WIDTH;

    logic signed [ELEM_WIDTH-1:0] a_mem [DEPTH];
    logic signed [ELEM_WIDTH-1:0] b_mem [DEPTH];

    logic signed [ELEM_WIDTH-1:0] a_q_reg, b_q_reg;
    logic signed [PW-1:0]         prod_reg;
    logic [mm_pkg::ACC_W-1:0]     acc_reg;
    logic [mm_pkg::ACC_W-1:0]     addend, acc_next;
    mm_pkg::mac_tag_t             tag1_reg, tag2_reg;

    mm_pkg::out_entry_t fifo_reg [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         cnt_reg, cnt_next;
    logic               push;

    // Stores: one write port, registered read of both
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && !cmd.wr_b)
        begin
            a_mem[wr_addr] <= element;
        end
        if (cmd.wr_en && cmd.wr_b)
        begin
            b_mem[wr_addr] <= element;
        end
        a_q_reg  <= a_mem[a_addr];
        b_q_reg  <= b_mem[b_addr];
        prod_reg <= a_q_reg * b_q_reg;
    end

    // Sums wrap modulo the result width
    generate
        if (PW >= mm_pkg::ACC_W)
        begin : g_trunc
            assign addend = prod_reg[mm_pkg::ACC_W-1:0];
        end
        else
        begin : g_sext
            assign addend = {{(mm_pkg::ACC_W - PW){prod_reg[PW-1]}}, prod_reg};
        end
    endgenerate

    assign acc_next = tag2_reg.first ? addend : acc_reg + addend;
    assign push     = tag2_reg.valid && tag2_reg.lastk;

    always_ff @(posedge clk)
    begin
        if (tag2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= '{value: acc_next, row: tag2_reg.row,
                                      col: tag2_reg.col, last: tag2_reg.last};
        end
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign out_entry = fifo_reg[rd_ptr_reg];
    assign out_pop   = out_valid && out_ready;

    always_comb
    begin
        unique case ({push, out_pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg   <= '0;
            tag2_reg   <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            tag1_reg <= cmd.tag;
            tag2_reg <= tag1_reg;
            cnt_reg  <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (out_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((cnt_reg != 2'd2) || out_pop))
        else $error("finished sum pushed into a full queue");

    a_tag_follows: assert property (@(posedge clk) disable iff (!rst_n)
        tag2_reg.valid |-> $past(cmd.tag.valid, 2))
        else $error("MAC tag appeared without an issued read");

endmodule

>>> hw/rtl/matrix_multiply.sv
// Top level of the dense matrix multiply block.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: element
//  m_axis    out  m_axis_tvalid/tready       tdata: product_value, result_row, result_col;
//                                            tlast: last_flag
//  cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// Loading accepts one element per cycle while s_axis_tvalid is high; s_axis_tready is low
// while the product is computed. The single MAC works through the result elements in turn,
// summing inner_used terms for each through the store-read and multiply registers;
// a two-entry result queue lets the next sum run while a word waits on m_axis.
// A stall on m_axis holds the MAC once both queue entries are reserved.
// Reset sets all three dimensions to 8 and empties the load; the stores are not cleared.
module matrix_multiply #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((ELEM_WIDTH+7)/8)*8-1:0]       s_axis_tdata,  // [ELEM_WIDTH-1:0] element
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [mm_pkg::OUT_DATA_W-1:0]         m_axis_tdata,  // product_value, row, col
    output logic                                  m_axis_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mm_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    mm_pkg::dp_cmd_t    cmd;
    mm_pkg::out_entry_t out_entry;
    logic [AW-1:0]      wr_addr, a_addr, b_addr;
    logic               out_pop;

    mm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_pop   (out_pop),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .a_addr    (a_addr),
        .b_addr    (b_addr)
    );

    mm_datapath #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .a_addr    (a_addr),
        .b_addr    (b_addr),
        .element   (s_axis_tdata[ELEM_WIDTH-1:0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_entry (out_entry),
        .out_pop   (out_pop)
    );

    assign m_axis_tdata = {{mm_pkg::OUT_PAD_W{1'b0}}, out_entry.col, out_entry.row,
                           out_entry.value};
    assign m_axis_tlast = out_entry.last;

endmodule

>>> test/testbench.sv
// Self-checking testbench for the dense matrix multiply block over its streaming ports.
`timescale 1ns / 1ps

module testbench;

    localparam int HALF_PERIOD = 5;
    localparam int SETTLE      = 12;    // pipeline drain before a register write
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int RANDOM_GOAL = 60;
    localparam logic [mm_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index, ignored

    typedef enum logic {SCRIPT_CFG, SCRIPT_ELEM} script_kind_t;

    typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_LOW_PEAK} fill_mode_t;

    // typed rows carry the single result of a one-element product matrix
    typedef struct packed {
        script_kind_t                     kind;
        logic [mm_pkg::CFG_IDX_W-1:0]     idx;
        logic [15:0]                      data;
        logic                             typed;
        logic signed [mm_pkg::ACC_W-1:0]  value;
    } script_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [15:0]                    s_axis_tdata;   // [15:0] element
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [mm_pkg::OUT_DATA_W-1:0]  m_axis_tdata;   // [34:0] value, [37:35] row, [40:38] col
    logic                           m_axis_tlast;   // last_flag
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [mm_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [mm_pkg::CFG_DATA_W-1:0]  cfg_data;

    matrix_multiply dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // predictor state
    logic [15:0]                    a_mem [64];
    logic [15:0]                    b_mem [64];
    int unsigned                    fill_count;
    logic [mm_pkg::CFG_DATA_W-1:0]  rows_raw;
    logic [mm_pkg::CFG_DATA_W-1:0]  inner_raw;
    logic [mm_pkg::CFG_DATA_W-1:0]  cols_raw;

    mm_pkg::out_entry_t     fresh_products[$];
    mm_pkg::out_entry_t     pending_products[$];
    script_row_t            script[$];

    int unsigned            errors;
    int unsigned            words_sent;
    int unsigned            products_checked;
    int unsigned            matrices_done;
    int unsigned            reg_writes;
    bit                     hold_request;
    bit                     tx_calm;
    bit                     rx_calm;

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    function automatic int unsigned eff_dim(input logic [mm_pkg::CFG_DATA_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > 8)
            return 8;
        return 32'(raw);
    endfunction

    function automatic script_row_t cfg_row(input logic [mm_pkg::CFG_IDX_W-1:0] idx,
                                            input int val);
        script_row_t row;
        row = '0;
        row.kind = SCRIPT_CFG;
        row.idx  = idx;
        row.data = 16'(val);
        return row;
    endfunction

    function automatic script_row_t elem_row(input int e, input logic typed, input longint val);
        script_row_t row;
        row = '0;
        row.kind  = SCRIPT_ELEM;
        row.data  = 16'(e);
        row.typed = typed;
        row.value = val[mm_pkg::ACC_W-1:0];
        return row;
    endfunction

    task automatic add_row(input script_row_t row);
        script = {script, row};
    endtask

    function automatic logic [15:0] pick_element(input fill_mode_t mode, input bit in_b);
        unique case (mode)
            FILL_LOW_PEAK: return in_b ? 16'h7fff : 16'h8000;
            FILL_EXTREME:
                unique case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    3: return 16'hffff;
                    default: return 16'($urandom_range(0, 65535));
                endcase
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [mm_pkg::CFG_DATA_W-1:0] draw_dim();
        unique case ($urandom_range(0, 9))
            0: return 4'($urandom_range(0, 15));
            1: return 4'd8;
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    task automatic set_dim(input logic [mm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mm_pkg::CFG_DATA_W-1:0] val);
        unique case (idx)
            mm_pkg::REG_ROWS:  rows_raw  = val;
            mm_pkg::REG_INNER: inner_raw = val;
            mm_pkg::REG_COLS:  cols_raw  = val;
            default:           return;
        endcase
        fill_count = 0;     // any mapped write drops a partial load
    endtask

    // store one element; on the final B element work out the whole product
    task automatic absorb_element(input logic [15:0] e);
        int unsigned        r;
        int unsigned        n;
        int unsigned        c;
        int unsigned        a_len;
        longint             acc;
        mm_pkg::out_entry_t w;
        r = eff_dim(rows_raw);
        n = eff_dim(inner_raw);
        c = eff_dim(cols_raw);
        a_len = r * n;
        fresh_products.delete();
        if (fill_count < a_len)
            a_mem[fill_count] = e;
        else
            b_mem[fill_count - a_len] = e;
        fill_count++;
        if (fill_count == a_len + n * c)
        begin
            for (int j = 0; j < r; j++)
                for (int i = 0; i < c; i++)
                begin
                    acc = 0;
                    for (int k = 0; k < n; k++)
                        acc += longint'($signed(a_mem[j * n + k]))
                             * longint'($signed(b_mem[k * c + i]));
                    w.value = acc[mm_pkg::ACC_W-1:0];
                    w.row   = j[mm_pkg::IDX_W-1:0];
                    w.col   = i[mm_pkg::IDX_W-1:0];
                    w.last  = (j == r - 1) && (i == c - 1);
                    fresh_products = {fresh_products, w};
                end
            fill_count = 0;
            matrices_done++;
        end
    endtask

    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mm_pkg::CFG_DATA_W-1:0] val);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        set_dim(idx, val);
        reg_writes++;
    endtask

    task automatic send_element(input logic [15:0] e, input logic typed,
                                input logic [mm_pkg::ACC_W-1:0] typed_value);
        int unsigned        gap;
        mm_pkg::out_entry_t w;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= e;
        do @(posedge clk); while (!s_axis_tready);
        words_sent++;
        absorb_element(e);
        if (typed)
        begin
            w.value = typed_value;
            w.row   = '0;
            w.col   = '0;
            w.last  = 1'b1;
            pending_products = {pending_products, w};
        end
        else
            foreach (fresh_products[q])
                pending_products = {pending_products, fresh_products[q]};
    endtask

    // one whole matrix pair, or a truncated one when cut_short is set
    task automatic send_matrices(input fill_mode_t mode, input bit cut_short,
                                 output int unsigned sent);
        int unsigned a_len;
        int unsigned total;
        int unsigned limit;
        a_len = eff_dim(rows_raw) * eff_dim(inner_raw);
        total = a_len + eff_dim(inner_raw) * eff_dim(cols_raw);
        limit = cut_short ? $urandom_range(1, total - 1) : total;
        if ($urandom_range(0, 3) == 0)
            tx_calm = ~tx_calm;
        for (int k = 0; k < limit; k++)
            send_element(pick_element(mode, k >= a_len), 1'b0, '0);
        sent = limit;
    endtask

    task automatic note_mismatch(input string what, input longint want, input longint got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    // result receiver: random back-pressure, checks each word against the oldest expectation
    initial
    begin
        mm_pkg::out_entry_t want;
        int unsigned        gap;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            if ($urandom_range(0, 15) == 0)
                rx_calm = ~rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, 9);
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            if (pending_products.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none, got value %0d",
                         $time, $signed(m_axis_tdata[mm_pkg::ACC_W-1:0]));
            end
            else
            begin
                want = pending_products.pop_front();
                products_checked++;
                if (m_axis_tdata[mm_pkg::ACC_W-1:0] != want.value)
                    note_mismatch("value", longint'($signed(want.value)),
                                  longint'($signed(m_axis_tdata[mm_pkg::ACC_W-1:0])));
                if (m_axis_tdata[mm_pkg::ACC_W +: mm_pkg::IDX_W] != want.row)
                    note_mismatch("row", want.row,
                                  m_axis_tdata[mm_pkg::ACC_W +: mm_pkg::IDX_W]);
                if (m_axis_tdata[mm_pkg::ACC_W + mm_pkg::IDX_W +: mm_pkg::IDX_W] != want.col)
                    note_mismatch("col", want.col,
                                  m_axis_tdata[mm_pkg::ACC_W + mm_pkg::IDX_W +: mm_pkg::IDX_W]);
                if (m_axis_tlast != want.last)
                    note_mismatch("last", want.last, m_axis_tlast);
            end
        end
    end

    // stimulus
    initial
    begin
        int unsigned                    random_words;
        int unsigned                    sent;
        int unsigned                    phase;
        int unsigned                    loads;
        bit                             must_write;
        bit                             wrote;
        bit                             cut_short;
        fill_mode_t                     mode;
        logic [mm_pkg::CFG_DATA_W-1:0]  dim;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= mm_pkg::REG_ROWS;
        cfg_data      <= '0;
        errors = 0;
        words_sent = 0;
        products_checked = 0;
        matrices_done = 0;
        reg_writes = 0;
        hold_request = 1'b0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        fill_count = 0;
        rows_raw  = 4'd8;
        inner_raw = 4'd8;
        cols_raw  = 4'd8;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset dimensions: one full 8x8 by 8x8 product
        send_matrices(FILL_RANDOM, 1'b0, sent);

        // directed rows
        add_row(cfg_row(mm_pkg::REG_ROWS, 1));
        add_row(cfg_row(mm_pkg::REG_INNER, 1));
        add_row(cfg_row(mm_pkg::REG_COLS, 1));
        add_row(cfg_row(REG_SPARE, 15));
        add_row(elem_row(32767, 1'b0, 0));
        add_row(elem_row(32767, 1'b1, 64'sd1073676289));
        add_row(elem_row(-32768, 1'b0, 0));
        add_row(elem_row(-32768, 1'b1, 64'sd1073741824));
        add_row(elem_row(-32768, 1'b0, 0));
        add_row(elem_row(32767, 1'b1, -64'sd1073709056));
        add_row(elem_row(0, 1'b0, 0));
        add_row(elem_row(-1, 1'b1, 0));
        // partial load, then a write that drops it; zero acts as one, fifteen as eight
        add_row(elem_row(12345, 1'b0, 0));
        add_row(cfg_row(mm_pkg::REG_ROWS, 0));
        add_row(cfg_row(mm_pkg::REG_INNER, 15));
        add_row(cfg_row(mm_pkg::REG_COLS, 0));
        for (int k = 0; k < 15; k++)
            add_row(elem_row(-32768, 1'b0, 0));
        add_row(elem_row(-32768, 1'b1, 64'sd8589934592));

        foreach (script[s])
        begin
            if (script[s].kind == SCRIPT_CFG)
                write_reg(script[s].idx, script[s].data[mm_pkg::CFG_DATA_W-1:0]);
            else
                send_element(script[s].data, script[s].typed, script[s].value);
        end

        // random part
        random_words = 0;
        phase = 0;
        must_write = 1'b0;
        while ((random_words < RANDOM_GOAL) || (phase < 3))
        begin
            mode = fill_mode_t'($urandom_range(0, 1));
            if (phase == 0)
            begin
                // most negative sum: 8 terms of -32768 * 32767
                write_reg(mm_pkg::REG_ROWS, 4'd1);
                write_reg(mm_pkg::REG_INNER, 4'd8);
                write_reg(mm_pkg::REG_COLS, 4'd2);
                mode = FILL_LOW_PEAK;
            end
            else if (phase == 2)
            begin
                // four results per load, more than the output queue holds
                write_reg(mm_pkg::REG_ROWS, 4'd2);
                write_reg(mm_pkg::REG_INNER, 4'd1);
                write_reg(mm_pkg::REG_COLS, 4'd2);
            end
            else
            begin
                wrote = 1'b0;
                for (int idx = 0; idx < 3; idx++)
                    if ($urandom_range(0, 1) == 1)
                    begin
                        dim = draw_dim();
                        write_reg(mm_pkg::CFG_IDX_W'(idx), dim);
                        wrote = 1'b1;
                    end
                if (must_write && !wrote)
                    write_reg(mm_pkg::REG_ROWS, draw_dim());
            end
            must_write = 1'b0;

            loads = $urandom_range(1, 3);
            if (phase == 0)
                loads = 1;
            if (phase == 2)
            begin
                // receiver stalls while the sender keeps feeding the next matrices
                hold_request = 1'b1;
                loads = 2;
            end
            for (int m = 0; m < loads; m++)
            begin
                cut_short = (phase != 0) && (phase != 2) && ($urandom_range(0, 7) == 0)
                         && (eff_dim(rows_raw) * eff_dim(inner_raw)
                             + eff_dim(inner_raw) * eff_dim(cols_raw) > 1);
                send_matrices(mode, cut_short, sent);
                random_words += sent;
                if (cut_short)
                begin
                    must_write = 1'b1;
                    break;
                end
            end
            if (phase == 4)
                wait_quiet();
            phase++;
        end

        wait_quiet();
        if (fill_count != 0)
            write_reg(mm_pkg::REG_ROWS, rows_raw);   // flush a trailing partial load
        wait_quiet();
        $display("Covered %0d input words, %0d matrix products, %0d register writes,",
                 words_sent, matrices_done, reg_writes);
        $display("%0d result words checked, %0d errors.", products_checked, errors);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/mm_pkg.sv
hw/rtl/mm_ctrl.sv
hw/rtl/mm_datapath.sv
hw/rtl/matrix_multiply.sv
test/testbench.sv
